// File: hdl/u8he_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8he_pkg
// Shared types, constants and helpers for the UTF-8 aware hex escaper.
// ----------------------------------------------------------------------------
package u8he_pkg;

   localparam int CAPACITY_BITS_DEF = 16;
   localparam int RESET_CAPACITY    = 256;
   localparam int PEND_DEPTH        = 6;
   localparam int HEAD_LEN          = 4;
   localparam int CSR_ADDR_BITS     = 3;

   localparam logic [7:0] CHR_BSLASH = 8'h5c;
   localparam logic [7:0] CHR_X      = 8'h78;

   typedef logic [2:0]                   pend_cnt_type;
   typedef logic [HEAD_LEN-1:0][7:0]     head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RAW,
      ST_ESC,
      ST_CHECK,
      ST_END
   } state_type;

   // Buffer operations requested by the sequencer.
   typedef struct packed {
      logic       append;
      logic       drop;
      logic       clear;
      logic [7:0] data;
   } buf_ctl_type;

   // Decision for the byte at the head of the pending buffer.
   typedef struct packed {
      logic         empty;
      logic         wait_more;
      logic         raw;
      pend_cnt_type raw_len;
   } class_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'd0, nib};
      end else begin
         r = 8'h57 + {4'd0, nib};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/u8he_class.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8he_class
// Classifies the head of the pending buffer: wait, raw unit or escape.
// ----------------------------------------------------------------------------
module u8he_class (
   input  wire u8he_pkg::head_type     head,
   input  wire u8he_pkg::pend_cnt_type cnt,
   input  wire                         eos,
   output u8he_pkg::class_type         cls
);
   import u8he_pkg::*;

   logic [7:0]   b0, b1, b2, b3;
   pend_cnt_type len;
   logic         c1, c2, c3;
   logic [10:0]  v2;
   logic [15:0]  v3;
   logic [20:0]  v4;
   logic         ok2, ok3, ok4, valid, plain;

   // expected sequence length from the lead byte (0 = never a lead)
   always_comb begin
      b0 = head[0];
      b1 = head[1];
      b2 = head[2];
      b3 = head[3];
      if (b0[7] == 1'b0)               len = 3'd1;
      else if (b0[7:5] == 3'b110)      len = 3'd2;
      else if (b0[7:4] == 4'b1110)     len = 3'd3;
      else if (b0[7:3] == 5'b11110)    len = 3'd4;
      else if (b0[7:2] == 6'b111110)   len = 3'd5;
      else if (b0[7:1] == 7'b1111110)  len = 3'd6;
      else                             len = 3'd0;
   end

   always_comb begin
      c1 = (b1[7:6] == 2'b10);
      c2 = (b2[7:6] == 2'b10);
      c3 = (b3[7:6] == 2'b10);
      v2 = {b0[4:0], b1[5:0]};
      v3 = {b0[3:0], b1[5:0], b2[5:0]};
      v4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      ok2 = c1 && (v2 >= 11'h080);
      ok3 = c1 && c2 && (v3 >= 16'h0800) && (v3[15:11] != 5'b11011) &&
            !((v3 > 16'hfdcf) && (v3 < 16'hfdf0)) && (v3 != 16'hffff);
      ok4 = c1 && c2 && c3 && (v4 >= 21'h010000) && (v4 <= 21'h10ffff) &&
            (v4[15:0] != 16'hffff);
      // five and six byte forms always exceed the code space
      case (len)
         3'd2:    valid = (cnt >= 3'd2) && ok2;
         3'd3:    valid = (cnt >= 3'd3) && ok3;
         3'd4:    valid = (cnt >= 3'd4) && ok4;
         default: valid = 1'b0;
      endcase
      plain = (b0 inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
                          8'h23, 8'h2b, 8'h2d, 8'h2e, 8'h3a, 8'h3d, 8'h40, 8'h5f});
   end

   always_comb begin
      cls.empty     = (cnt == 3'd0);
      cls.wait_more = (len > 3'd1) && (cnt < len) && !eos;
      cls.raw       = valid || plain;
      cls.raw_len   = valid ? len : 3'd1;
   end

endmodule
`default_nettype wire

// File: hdl/u8he_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8he_buf
// Pending byte queue: append at the tail, drop from the head by shifting.
// ----------------------------------------------------------------------------
module u8he_buf (
   input  wire                         clock,
   input  wire                         reset,
   input  wire u8he_pkg::buf_ctl_type  ctl,
   output u8he_pkg::head_type          head,
   output u8he_pkg::pend_cnt_type      cnt
);
   import u8he_pkg::*;

   logic [PEND_DEPTH-1:0][7:0] data_ff, data_in;
   pend_cnt_type               cnt_ff, cnt_in;

   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (ctl.clear) begin
         cnt_in = 3'd0;
      end else if (ctl.drop) begin
         for (int i = 0; i < PEND_DEPTH - 1; i++) begin
            data_in[i] = data_ff[i+1];
         end
         cnt_in = cnt_ff - 3'd1;
      end else if (ctl.append) begin
         for (int i = 0; i < PEND_DEPTH; i++) begin
            if (3'(i) == cnt_ff) data_in[i] = ctl.data;
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign head = data_ff[HEAD_LEN-1:0];
   assign cnt  = cnt_ff;

endmodule
`default_nettype wire

// File: hdl/utf8_aware_hex_escaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_aware_hex_escaper
// Byte stream escaper: passes valid UTF-8 and safe ASCII, hex-escapes the rest.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in IDLE and classified in DECIDE; each output
//   character is sent from RAW or ESC, and each unit adds a CHECK and a further
//   DECIDE; END closes the request, or CHECK does on overflow. A failed six-byte
//   lead is rescanned as six escapes. A discarded request is taken in IDLE and
//   the sequencer stays there.
// Throughput: one request at a time; the sequencer and its single count/compare
//   path set the rate. Output stalls hold the sequencer.
// Reset: synchronous, active high; clears queue count, counters, flags and
//   loads out_capacity = 256 (truncated to CAPACITY_BITS).
// ----------------------------------------------------------------------------
module utf8_aware_hex_escaper #(
   parameter int CAPACITY_BITS = u8he_pkg::CAPACITY_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request stream
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [7:0]                          req_tdata,   // [7:0] in_byte
   input  wire                                 req_tlast,   // end_of_string
   input  wire                                 req_tuser,   // [0] byte_present
   // response stream
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] out_byte
   output logic                                rsp_tlast,   // string_done
   output logic [1:0]                          rsp_tuser,   // [0] char_valid, [1] overflow
   // register port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [u8he_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import u8he_pkg::*;

   localparam int CNT_BITS = CAPACITY_BITS + 1;
   localparam int SUM_BITS = CAPACITY_BITS + 2;

   state_type              state_ff, state_in;
   logic [CAPACITY_BITS-1:0] cap_ff, cap_in;
   logic [CNT_BITS-1:0]    emit_ff, emit_in;     // characters sent in this string
   logic                   disc_ff, disc_in;     // dropping until end of string
   logic                   eos_ff, eos_in;       // current request ends the string
   pend_cnt_type           rem_ff, rem_in;       // raw bytes left in this unit
   logic [1:0]             eidx_ff, eidx_in;     // escape character index
   logic [7:0]             ebyte_ff, ebyte_in;   // byte being escaped

   logic                   rvalid_ff, rvalid_in;
   logic [7:0]             rbyte_ff, rbyte_in;
   logic                   rchar_ff, rchar_in;
   logic                   rdone_ff, rdone_in;
   logic                   rovf_ff, rovf_in;

   buf_ctl_type            bctl;
   head_type               head;
   pend_cnt_type           pcnt;
   class_type              cls;

   logic                   req_hs, out_free, emit, cap_hit, csr_wr;
   logic [SUM_BITS-1:0]    sum;

   u8he_buf u_buf (
      .clock (clock),
      .reset (reset),
      .ctl   (bctl),
      .head  (head),
      .cnt   (pcnt)
   );

   u8he_class u_class (
      .head (head),
      .cnt  (pcnt),
      .eos  (eos_ff),
      .cls  (cls)
   );

   // -------------------------------------------------------------- registers
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(cap_ff);
   assign cap_in     = (csr_wr && !csr_paddr[2]) ? csr_pwdata[CAPACITY_BITS-1:0] : cap_ff;

   // shared count/compare path: count + 3 against capacity
   assign sum     = SUM_BITS'(emit_ff) + SUM_BITS'(3);
   assign cap_hit = (sum >= SUM_BITS'(cap_ff));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_hs     = req_tvalid && req_tready;
   assign out_free   = !rvalid_ff || rsp_tready;

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_hs && !disc_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cls.empty || cls.wait_more) state_in = ST_END;
            else if (cls.raw)               state_in = ST_RAW;
            else                            state_in = ST_ESC;
         end
         ST_RAW: begin
            if (out_free && (rem_ff == 3'd1)) state_in = ST_CHECK;
         end
         ST_ESC: begin
            if (out_free && (eidx_ff == 2'd3)) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!cap_hit)     state_in = ST_DECIDE;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_END: begin
            if (!eos_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      emit_in  = emit_ff;
      disc_in  = disc_ff;
      eos_in   = eos_ff;
      rem_in   = rem_ff;
      eidx_in  = eidx_ff;
      ebyte_in = ebyte_ff;
      bctl     = '0;
      bctl.data = req_tdata;
      emit     = 1'b0;
      rbyte_in = 8'h00;
      rchar_in = 1'b0;
      rdone_in = 1'b0;
      rovf_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               if (disc_ff) begin
                  if (req_tlast) begin
                     disc_in    = 1'b0;
                     emit_in    = '0;
                     bctl.clear = 1'b1;
                  end
               end else begin
                  eos_in      = req_tlast;
                  bctl.append = req_tuser;
               end
            end
         end
         ST_DECIDE: begin
            rem_in   = cls.raw_len;
            eidx_in  = 2'd0;
            ebyte_in = head[0];
         end
         ST_RAW: begin
            if (out_free) begin
               emit      = 1'b1;
               rbyte_in  = head[0];
               rchar_in  = 1'b1;
               bctl.drop = 1'b1;
               emit_in   = emit_ff + CNT_BITS'(1);
               rem_in    = rem_ff - 3'd1;
            end
         end
         ST_ESC: begin
            if (out_free) begin
               emit     = 1'b1;
               rchar_in = 1'b1;
               emit_in  = emit_ff + CNT_BITS'(1);
               eidx_in  = eidx_ff + 2'd1;
               case (eidx_ff)
                  2'd0: begin
                     rbyte_in  = CHR_BSLASH;
                     bctl.drop = 1'b1;
                  end
                  2'd1:    rbyte_in = CHR_X;
                  2'd2:    rbyte_in = hex_char(ebyte_ff[7:4]);
                  default: rbyte_in = hex_char(ebyte_ff[3:0]);
               endcase
            end
         end
         ST_CHECK: begin
            if (cap_hit && out_free) begin
               emit       = 1'b1;
               rdone_in   = 1'b1;
               rovf_in    = 1'b1;
               bctl.clear = 1'b1;
               emit_in    = '0;
               disc_in    = !eos_ff;
            end
         end
         ST_END: begin
            if (eos_ff && out_free) begin
               emit       = 1'b1;
               rdone_in   = 1'b1;
               rovf_in    = (cap_ff == '0);
               bctl.clear = 1'b1;
               emit_in    = '0;
            end
         end
         default: begin
            bctl = '0;
         end
      endcase
   end

   // output register, loaded when free
   assign rvalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= CAPACITY_BITS'(RESET_CAPACITY);
         emit_ff   <= '0;
         disc_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         emit_ff   <= emit_in;
         disc_ff   <= disc_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      eos_ff   <= eos_in;
      rem_ff   <= rem_in;
      eidx_ff  <= eidx_in;
      ebyte_ff <= ebyte_in;
      if (emit) begin
         rbyte_ff <= rbyte_in;
         rchar_ff <= rchar_in;
         rdone_ff <= rdone_in;
         rovf_ff  <= rovf_in;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rbyte_ff;
   assign rsp_tlast  = rdone_ff;
   assign rsp_tuser  = {rovf_ff, rchar_ff};

   // ------------------------------------------------------------ assertions
   // queue never reaches full depth between requests
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pcnt < 3'(PEND_DEPTH)))
      else $error("pending queue full while idle");

   // dropping mode holds no pending bytes and no count
   a_disc_empty: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> ((pcnt == 3'd0) && (emit_ff == '0)))
      else $error("state left over while discarding");

   // character count never passes 2**CAPACITY_BITS
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      emit_ff[CAPACITY_BITS] |-> (emit_ff[CAPACITY_BITS-1:0] == '0))
      else $error("character count out of range");

   // a status response never carries a character
   a_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !rsp_tuser[0])
      else $error("status response flagged as character");

   // an overflow status always clears the count for the next string
   a_ovf_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && cap_hit && out_free) |=> (emit_ff == '0))
      else $error("count not cleared on overflow");

endmodule
`default_nettype wire
